@@ rtl/fpr_pkg.sv @@
// Package for the framed packet ring buffer: beat types, mode and status codes,
// frame constants and the controller state type.
// No dependencies.
package fpr_pkg;

  // Input beat modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_FLUSH = 2'd3;

  // Result status codes
  localparam logic [2:0] STATUS_ACCEPTED = 3'd0;
  localparam logic [2:0] STATUS_DROPPED  = 3'd1;
  localparam logic [2:0] STATUS_EMPTY    = 3'd2;
  localparam logic [2:0] STATUS_DATA     = 3'd3;
  localparam logic [2:0] STATUS_FLUSHED  = 3'd4;
  localparam logic [2:0] STATUS_SKIPPED  = 3'd5;

  // Frame layout: length byte holds payload + 2, then header, then payload
  localparam logic [5:0] CODE_MASK      = 6'h1F;
  localparam logic [3:0] NIBBLE_MASK    = 4'hF;
  localparam logic [5:0] FRAME_OVERHEAD = 6'd3;
  localparam logic [5:0] TOTAL_MAX      = CODE_MASK + FRAME_OVERHEAD;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] header_byte;
    logic [4:0] length_code;
    logic [7:0] payload_in;
    logic [7:0] read_limit;
  } in_beat_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] pipe_number;
    logic [3:0] rssi_level;
    logic [7:0] data_out;
    logic [5:0] frame_payload_len;
    logic       last;
  } out_beat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_WR,
    ST_RD_LEN,
    ST_RD_HDR,
    ST_RD_DATA
  } state_e;

endpackage

@@ rtl/framed_packet_ring_buffer_unit.sv @@
// Framed packet ring buffer: byte ring in one synchronous memory holding
// length-prefixed radio frames, with frame write, frame read and flush.
// Depends on fpr_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------
//   in      | input     | in_valid_i / in_stall_o  | fpr_pkg::in_beat_t
//   out     | output    | out_valid_o / out_stall_i| fpr_pkg::out_beat_t
//
// Payload byte, refused or dropped start, flush: one beat per cycle while not stalled.
// Accepted start: length byte in ST_IDLE, header in ST_HDR_WR (they share one write port).
// Frame read: length and header fetched via ST_RD_LEN, ST_RD_HDR, then one delivered
// byte per unstalled cycle; skipped bytes cost nothing, the read pointer jumps past them.
// Reset clears pointers and counters at once; the byte store is not cleared.
// A stalled output holds the read walk; the input is stalled while busy.
module framed_packet_ring_buffer_unit #(
  parameter int BUFFER_BYTES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fpr_pkg::in_beat_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fpr_pkg::out_beat_t  out_data_o
);
  import fpr_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_BYTES);
  localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BUFFER_BYTES - 1)) return '0;
    return p + 1'b1;
  endfunction

  // Byte store
  logic [7:0]       mem [BUFFER_BYTES];
  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata_q;

  // Control and pointer state
  state_e           state_q, state_d;
  logic [PTR_W-1:0] rp_q, rp_d, wp_q, wp_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] free_q, free_d, frames_q, frames_d;
  logic [5:0]       pending_q, pending_d;
  logic             dropping_q, dropping_d;
  logic [7:0]       hdr_q, hdr_d, limit_q, limit_d;
  logic [5:0]       total_q, total_d, plen_q, plen_d;
  logic [5:0]       deliver_q, deliver_d, cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  out_beat_t        out_q, out_d;

  // Decode
  logic             out_free, in_fire, room, start_hdr, start_read, last_beat;
  logic [5:0]       total_in, len_clamped, plen_rd;
  logic [PTR_W:0]   rp_sum;
  logic [CNT_W:0]   free_sum;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !((state_q == ST_IDLE) && out_free);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign total_in    = 6'(in_data_i.length_code) + FRAME_OVERHEAD;
  assign room        = free_q >= CNT_W'(total_in);
  assign start_hdr   = (in_data_i.mode == MODE_START) && (pending_q == '0) && room;
  assign start_read  = (in_data_i.mode == MODE_READ) && (in_data_i.read_limit != '0)
                       && (frames_q != '0);
  assign last_beat   = (cnt_q + 6'd1) == deliver_q;
  assign len_clamped = (mem_rdata_q < 8'(FRAME_OVERHEAD)) ? FRAME_OVERHEAD :
                       (mem_rdata_q > 8'(TOTAL_MAX))      ? TOTAL_MAX :
                       mem_rdata_q[5:0];
  assign plen_rd     = len_clamped - 6'd2;
  assign rp_sum      = {1'b0, rp_q} + (PTR_W+1)'(total_q);
  assign free_sum    = {1'b0, free_q} + (CNT_W+1)'(total_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && start_hdr) state_d = ST_HDR_WR;
        else if (in_fire && start_read) state_d = ST_RD_LEN;
      end
      ST_HDR_WR: state_d = ST_IDLE;
      ST_RD_LEN: state_d = ST_RD_HDR;
      ST_RD_HDR: state_d = ST_RD_DATA;
      ST_RD_DATA: begin
        if (out_free && last_beat) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath, memory access and results
  always_comb begin
    rp_d        = rp_q;
    wp_d        = wp_q;
    rd_ptr_d    = rd_ptr_q;
    free_d      = free_q;
    frames_d    = frames_q;
    pending_d   = pending_q;
    dropping_d  = dropping_q;
    hdr_d       = hdr_q;
    limit_d     = limit_q;
    total_d     = total_q;
    plen_d      = plen_q;
    deliver_d   = deliver_q;
    cnt_d       = cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = wp_q;
    mem_wdata   = 8'(total_in);
    mem_re      = 1'b0;
    mem_raddr   = rd_ptr_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d       = '0;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          unique case (in_data_i.mode)
            MODE_START: begin
              out_d.status = STATUS_DROPPED;
              if (pending_q == '0) begin
                pending_d  = 6'(in_data_i.length_code) + 6'd1;
                dropping_d = !room;
                if (room) begin
                  // write length byte now, header byte next cycle
                  mem_we       = 1'b1;
                  wp_d         = adv(wp_q);
                  hdr_d        = in_data_i.header_byte;
                  free_d       = free_q - CNT_W'(total_in);
                  out_d.status = STATUS_ACCEPTED;
                end
              end
            end
            MODE_BYTE: begin
              out_d.status = STATUS_DROPPED;
              if (pending_q != '0) begin
                pending_d = pending_q - 6'd1;
                if (dropping_q) begin
                  if (pending_q == 6'd1) dropping_d = 1'b0;
                end else begin
                  mem_we       = 1'b1;
                  mem_wdata    = in_data_i.payload_in;
                  wp_d         = adv(wp_q);
                  if (pending_q == 6'd1) frames_d = frames_q + 1'b1;
                  out_d.status = STATUS_ACCEPTED;
                end
              end
            end
            MODE_READ: begin
              if (in_data_i.read_limit == '0) begin
                out_d.status = STATUS_SKIPPED;
              end else if (frames_q == '0) begin
                out_d.status = STATUS_EMPTY;
              end else begin
                // fetch the length byte; results come from the walk
                out_valid_d = out_valid_q && out_stall_i;
                out_d       = out_q;
                mem_re      = 1'b1;
                mem_raddr   = rp_q;
                rd_ptr_d    = adv(rp_q);
                limit_d     = in_data_i.read_limit;
              end
            end
            MODE_FLUSH: begin
              rp_d         = '0;
              wp_d         = '0;
              free_d       = CNT_W'(BUFFER_BYTES);
              frames_d     = '0;
              pending_d    = '0;
              dropping_d   = 1'b0;
              out_d.status = STATUS_FLUSHED;
            end
            default: ;
          endcase
        end
      end

      ST_HDR_WR: begin
        mem_we    = 1'b1;
        mem_wdata = hdr_q;
        wp_d      = adv(wp_q);
      end

      ST_RD_LEN: begin
        total_d   = len_clamped;
        plen_d    = plen_rd;
        deliver_d = (limit_q < 8'(plen_rd)) ? limit_q[5:0] : plen_rd;
        mem_re    = 1'b1;
        rd_ptr_d  = adv(rd_ptr_q);
      end

      ST_RD_HDR: begin
        hdr_d    = mem_rdata_q;
        cnt_d    = '0;
        mem_re   = 1'b1;
        rd_ptr_d = adv(rd_ptr_q);
      end

      ST_RD_DATA: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.status            = STATUS_DATA;
          out_d.pipe_number       = hdr_q[3:0] & NIBBLE_MASK;
          out_d.rssi_level        = hdr_q[7:4] & NIBBLE_MASK;
          out_d.data_out          = mem_rdata_q;
          out_d.frame_payload_len = plen_q;
          out_d.last              = last_beat;
          if (last_beat) begin
            // pop the whole frame, skipping undelivered bytes
            rp_d     = (rp_sum >= (PTR_W+1)'(BUFFER_BYTES)) ?
                       PTR_W'(rp_sum - (PTR_W+1)'(BUFFER_BYTES)) : PTR_W'(rp_sum);
            free_d   = (free_sum > (CNT_W+1)'(BUFFER_BYTES)) ?
                       CNT_W'(BUFFER_BYTES) : CNT_W'(free_sum);
            frames_d = frames_q - 1'b1;
          end else begin
            cnt_d    = cnt_q + 6'd1;
            mem_re   = 1'b1;
            rd_ptr_d = adv(rd_ptr_q);
          end
        end
      end

      default: ;
    endcase
  end

  // Memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rp_q        <= '0;
      wp_q        <= '0;
      free_q      <= CNT_W'(BUFFER_BYTES);
      frames_q    <= '0;
      pending_q   <= '0;
      dropping_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      free_q      <= free_d;
      frames_q    <= frames_d;
      pending_q   <= pending_d;
      dropping_q  <= dropping_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    rd_ptr_q  <= rd_ptr_d;
    hdr_q     <= hdr_d;
    limit_q   <= limit_d;
    total_q   <= total_d;
    plen_q    <= plen_d;
    deliver_q <= deliver_d;
    cnt_q     <= cnt_d;
    out_q     <= out_d;
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for framed_packet_ring_buffer_unit: frame writes, reads, drops
// and flushes checked beat by beat against a behavioral ring model in this file.
// Depends on fpr_pkg and the block RTL.
module tb;
  import fpr_pkg::*;

  localparam int BUF_BYTES     = 256;
  localparam int HOLD_CYCLES   = 300;
  localparam int STUCK_LIMIT   = 3000;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_BEATS  = 6;

  logic      clk_i;
  logic      rst_n     = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;

  int in_idle_pct   = 0;
  int out_idle_pct  = 0;
  int hold_requests = 0;
  int err_count     = 0;
  int beats_sent    = 0;
  int stuck_cycles  = 0;

  // Ring model state
  logic [7:0]  ring_mem [BUF_BYTES];
  int unsigned rd_ptr, wr_ptr, free_cnt, frame_cnt, pend_cnt;
  bit          drop_open;
  out_beat_t   pending_results [$];

  framed_packet_ring_buffer_unit #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_beat)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- ring model
  function automatic void ring_put(logic [7:0] v);
    ring_mem[wr_ptr[7:0]] = v;
    wr_ptr = (wr_ptr + 1) % BUF_BYTES;
  endfunction

  function automatic logic [7:0] ring_take();
    logic [7:0] v;
    v = ring_mem[rd_ptr[7:0]];
    rd_ptr = (rd_ptr + 1) % BUF_BYTES;
    return v;
  endfunction

  function automatic out_beat_t status_beat(logic [2:0] st);
    out_beat_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic void ring_clear();
    rd_ptr    = 0;
    wr_ptr    = 0;
    free_cnt  = BUF_BYTES;
    frame_cnt = 0;
    pend_cnt  = 0;
    drop_open = 1'b0;
  endfunction

  // Compute the result beats of one accepted input beat and queue them
  function automatic void predict_ring_results(in_beat_t b);
    int unsigned total, plen, deliver;
    logic [7:0]  hdr, byte_v;
    out_beat_t   r;
    case (b.mode)
      MODE_START: begin
        total = int'(b.length_code) + int'(FRAME_OVERHEAD);
        if (pend_cnt != 0) begin
          pending_results.push_back(status_beat(STATUS_DROPPED));
        end else if (free_cnt >= total) begin
          ring_put(total[7:0]);
          ring_put(b.header_byte);
          free_cnt -= total;
          pend_cnt = int'(b.length_code) + 1;
          drop_open = 1'b0;
          pending_results.push_back(status_beat(STATUS_ACCEPTED));
        end else begin
          pend_cnt = int'(b.length_code) + 1;
          drop_open = 1'b1;
          pending_results.push_back(status_beat(STATUS_DROPPED));
        end
      end
      MODE_BYTE: begin
        if (pend_cnt == 0) begin
          pending_results.push_back(status_beat(STATUS_DROPPED));
        end else begin
          pend_cnt--;
          if (drop_open) begin
            if (pend_cnt == 0) drop_open = 1'b0;
            pending_results.push_back(status_beat(STATUS_DROPPED));
          end else begin
            ring_put(b.payload_in);
            if (pend_cnt == 0) frame_cnt++;
            pending_results.push_back(status_beat(STATUS_ACCEPTED));
          end
        end
      end
      MODE_READ: begin
        if (b.read_limit == 0) begin
          pending_results.push_back(status_beat(STATUS_SKIPPED));
        end else if (frame_cnt == 0) begin
          pending_results.push_back(status_beat(STATUS_EMPTY));
        end else begin
          total = 32'(ring_take());
          if (total < 32'(FRAME_OVERHEAD)) total = 32'(FRAME_OVERHEAD);
          if (total > 32'(TOTAL_MAX)) total = 32'(TOTAL_MAX);
          hdr = ring_take();
          plen = total - 2;
          deliver = (32'(b.read_limit) < plen) ? 32'(b.read_limit) : plen;
          // Walk the whole frame; only the first bytes up to the limit come out
          for (int i = 0; i < plen; i++) begin
            byte_v = ring_take();
            if (i < deliver) begin
              r = '0;
              r.status = STATUS_DATA;
              r.pipe_number = hdr[3:0];
              r.rssi_level = hdr[7:4];
              r.data_out = byte_v;
              r.frame_payload_len = plen[5:0];
              r.last = (i + 1 == deliver);
              pending_results.push_back(r);
            end
          end
          free_cnt += total;
          if (free_cnt > BUF_BYTES) free_cnt = BUF_BYTES;
          frame_cnt--;
        end
      end
      default: begin
        ring_clear();
        pending_results.push_back(status_beat(STATUS_FLUSHED));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- beat builders
  function automatic in_beat_t rand_beat(logic [1:0] m);
    logic [31:0] raw;
    in_beat_t    b;
    raw = $urandom;
    b = raw[$bits(in_beat_t)-1:0];
    b.mode = m;
    return b;
  endfunction

  function automatic in_beat_t start_beat(int code, logic [7:0] hdr);
    in_beat_t b;
    b = rand_beat(MODE_START);
    b.length_code = code[4:0];
    b.header_byte = hdr;
    return b;
  endfunction

  function automatic in_beat_t byte_beat(logic [7:0] v);
    in_beat_t b;
    b = rand_beat(MODE_BYTE);
    b.payload_in = v;
    return b;
  endfunction

  function automatic in_beat_t read_beat(int lim);
    in_beat_t b;
    b = rand_beat(MODE_READ);
    b.read_limit = lim[7:0];
    return b;
  endfunction

  function automatic int pick_limit();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 0;
    if (sel < 20) return 255;
    if (sel < 30) return $urandom_range(255);
    return $urandom_range(40, 1);
  endfunction

  // ---------------------------------------------------------------- driver
  // Offer one beat, with random idle cycles ahead of it, and hold it until taken
  task automatic offer_beat(input in_beat_t b);
    if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1'b1;
    in_beat <= b;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    predict_ring_results(b);
    beats_sent++;
  endtask

  task automatic send_frame(int code, logic [7:0] hdr);
    offer_beat(start_beat(code, hdr));
    for (int k = 0; k <= code; k++) offer_beat(byte_beat(8'($urandom)));
  endtask

  // ---------------------------------------------------------------- receiver
  // Stall at random, or for a long stretch when a hold-off is requested
  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk_i);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < out_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------- checker
  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  always @(posedge clk_i) begin : result_check
    out_beat_t want;
    if (out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result beat with none expected: status %0d data %0d",
               out_beat.status, out_beat.data_out);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_beat.status));
        check_field("pipe_number", 32'(want.pipe_number), 32'(out_beat.pipe_number));
        check_field("rssi_level", 32'(want.rssi_level), 32'(out_beat.rssi_level));
        check_field("data_out", 32'(want.data_out), 32'(out_beat.data_out));
        check_field("frame_payload_len", 32'(want.frame_payload_len),
                    32'(out_beat.frame_payload_len));
        check_field("last", 32'(want.last), 32'(out_beat.last));
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
  end

  initial begin : watchdog
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk_i);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  // Empty reads, zero limit, orphan byte, refused start, partial read, flush
  task automatic test_directed_cases();
    offer_beat(read_beat(5));
    offer_beat(read_beat(0));
    offer_beat(byte_beat(8'hA5));
    offer_beat(start_beat(0, 8'h00));
    offer_beat(byte_beat(8'hFF));
    offer_beat(start_beat(2, 8'hFF));
    offer_beat(start_beat(31, 8'h3C));
    offer_beat(read_beat(9));
    offer_beat(byte_beat(8'h00));
    offer_beat(byte_beat(8'h80));
    offer_beat(byte_beat(8'h7F));
    offer_beat(read_beat(0));
    offer_beat(read_beat(1));
    offer_beat(read_beat(255));
    offer_beat(start_beat(1, 8'h5A));
    offer_beat(byte_beat(8'h11));
    offer_beat(rand_beat(MODE_FLUSH));
    offer_beat(byte_beat(8'h22));
    offer_beat(read_beat(1));
    send_frame(3, 8'h96);
    offer_beat(read_beat(255));
  endtask

  // Largest frame, read one short of full
  task automatic test_longest_frame();
    send_frame(31, 8'($urandom));
    offer_beat(read_beat(31));
  endtask

  // Fill the ring to the last byte, drop frames that do not fit, then read
  // against a long receiver hold-off so the block backs up its input
  task automatic test_fill_and_hold();
    for (int f = 0; f < 7; f++) send_frame(31, 8'($urandom));
    send_frame(16, 8'($urandom));
    send_frame(15, 8'($urandom));
    send_frame(0, 8'($urandom));
    hold_requests++;
    for (int r = 0; r < 3; r++) offer_beat(read_beat(255));
    send_frame(2, 8'($urandom));
    for (int r = 0; r < 7; r++) offer_beat(read_beat($urandom_range(40, 1)));
    offer_beat(read_beat(200));
  endtask

  // Mostly well-formed frames and reads, with broken frames, flushes and noise
  task automatic test_random_traffic(int n_beats);
    int stop_at;
    int kind;
    int code;
    int part;
    stop_at = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 45) begin
        code = ($urandom_range(3) == 0) ? $urandom_range(31) : $urandom_range(5);
        send_frame(code, 8'($urandom));
      end else if (kind < 83) begin
        offer_beat(read_beat(pick_limit()));
      end else if (kind < 86) begin
        offer_beat(rand_beat(MODE_FLUSH));
      end else if (kind < 94) begin
        // Interrupt an open frame, then finish it or flush it
        code = $urandom_range(7);
        part = $urandom_range(code);
        offer_beat(start_beat(code, 8'($urandom)));
        for (int k = 0; k < part; k++) offer_beat(byte_beat(8'($urandom)));
        offer_beat(($urandom_range(1) == 0) ? start_beat($urandom_range(31), 8'($urandom))
                                            : read_beat(pick_limit()));
        if ($urandom_range(3) == 0) begin
          offer_beat(rand_beat(MODE_FLUSH));
        end else begin
          for (int k = part; k <= code; k++) offer_beat(byte_beat(8'($urandom)));
        end
      end else begin
        offer_beat(rand_beat(2'($urandom_range(3))));
      end
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    ring_clear();
    rst_n <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    in_idle_pct = 20;
    out_idle_pct = 60;
    test_directed_cases();
    test_longest_frame();
    test_fill_and_hold();
    test_random_traffic(RANDOM_BEATS);

    in_idle_pct = 60;
    out_idle_pct = 20;
    test_random_traffic(RANDOM_BEATS);

    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_traffic(RANDOM_BEATS);

    // Drain outstanding results, then watch for strays
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
